// ===== rtl/core/cesc_pkg.sv =====
// ----------------------------------------------------------------------------
// cesc_pkg
// Shared types, character constants and the escape-letter table for the
// C-style escape decoder.
// ----------------------------------------------------------------------------
package cesc_pkg;

  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned DigitWidth = 6;
  localparam int unsigned MaxResults = 4;

  localparam logic [ByteWidth-1:0] BACKSLASH  = 8'h5C;
  localparam logic [ByteWidth-1:0] QUOTE      = 8'h22;
  localparam logic [ByteWidth-1:0] OCTAL_LOW  = 8'h30;
  localparam logic [ByteWidth-1:0] OCTAL_HIGH = 8'h37;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SLASH = 2'd1,
    PH_ONE   = 2'd2,
    PH_TWO   = 2'd3
  } phase_t;

  typedef struct packed {
    logic                 hit;
    logic [ByteWidth-1:0] code;
  } letter_t;

  // Map an escape letter to its control byte.
  function automatic letter_t letter_lookup(input logic [ByteWidth-1:0] ch);
    letter_t res;
    res.hit  = 1'b1;
    res.code = ch;
    case (ch)
      BACKSLASH: res.code = BACKSLASH;
      QUOTE:     res.code = QUOTE;
      8'h61:     res.code = 8'h07;  // a
      8'h62:     res.code = 8'h08;  // b
      8'h74:     res.code = 8'h09;  // t
      8'h6E:     res.code = 8'h0A;  // n
      8'h76:     res.code = 8'h0B;  // v
      8'h66:     res.code = 8'h0C;  // f
      8'h72:     res.code = 8'h0D;  // r
      default:   res.hit  = 1'b0;
    endcase
    return res;
  endfunction

  // ASCII character of one octal digit.
  function automatic logic [ByteWidth-1:0] digit_char(input logic [2:0] d);
    return OCTAL_LOW | {5'd0, d};
  endfunction

endpackage

// ===== rtl/core/c_style_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// c_style_escape_decoder
// Path: an accepted byte waits in the input register until the result
//   register drains, then its results are loaded there and presented.
// Throughput: one input byte per cycle while each byte yields at most one
//   result and out_stall is low; a byte yielding two or more results stalls
//   the input until the single-byte output port is taking the last of them
//   from the result register.
// Reset: synchronous, clears the escape phase, held digits and both stages.
// ----------------------------------------------------------------------------
module c_style_escape_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cesc_pkg::ByteWidth-1:0] text_byte,
  input  logic                          end_of_text,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cesc_pkg::ByteWidth-1:0] plain_byte,
  output logic                          end_of_output
);
  import cesc_pkg::*;

  // input register
  logic                 hold_valid;
  logic [ByteWidth-1:0] hold_byte;
  logic                 hold_last;

  // escape state
  phase_t                phase;
  phase_t                phase_next;
  phase_t                mid_phase;
  logic [DigitWidth-1:0] digits;
  logic [DigitWidth-1:0] digits_next;
  logic [DigitWidth-1:0] mid_digits;

  // result register
  logic [ByteWidth-1:0] res_byte [MaxResults];
  logic [2:0]           res_left;
  logic [1:0]           res_idx;
  logic                 res_end;

  // decoded result list
  logic [ByteWidth-1:0] seq [MaxResults];
  logic [2:0]           seq_cnt;

  logic    take;
  logic    drain_ok;
  logic    move;
  logic    accept;
  logic    is_octal;
  logic    plain_pass;
  letter_t letter;
  logic [8:0] octal_value;

  assign take     = out_valid && !out_stall;
  assign drain_ok = (res_left == 3'd0) || ((res_left == 3'd1) && take);
  assign move     = hold_valid && drain_ok;
  assign in_stall = hold_valid && !drain_ok;
  assign accept   = in_valid && !in_stall;

  assign is_octal    = hold_byte inside {[OCTAL_LOW:OCTAL_HIGH]};
  assign letter      = letter_lookup(hold_byte);
  assign octal_value = {digits, hold_byte[2:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (move) begin
      hold_valid <= 1'b0;
    end
    if (accept) begin
      hold_byte <= text_byte;
      hold_last <= end_of_text;
    end
  end

  // Phase after this byte, before any end-of-text flush, and the stored phase and digits, cleared at end of text.
  always_comb begin : next_phase
    mid_phase  = (hold_byte == BACKSLASH) ? PH_SLASH : PH_IDLE;
    mid_digits = '0;
    case (phase)
      PH_IDLE: begin
      end
      PH_SLASH: begin
        if (letter.hit) begin
          mid_phase = PH_IDLE;
        end else if (is_octal) begin
          mid_phase  = PH_ONE;
          mid_digits = {3'd0, hold_byte[2:0]};
        end
      end
      PH_ONE: begin
        if (is_octal) begin
          mid_phase  = PH_TWO;
          mid_digits = {digits[2:0], hold_byte[2:0]};
        end
      end
      PH_TWO: begin
        if (is_octal) begin
          mid_phase = PH_IDLE;
        end
      end
      default: begin
        mid_phase = PH_IDLE;
      end
    endcase
    phase_next  = hold_last ? PH_IDLE : mid_phase;
    digits_next = hold_last ? '0 : mid_digits;
  end

  // Results of this byte, then the flush of whatever is still pending.
  always_comb begin : decode_results
    for (int i = 0; i < MaxResults; i++) begin
      seq[i] = '0;
    end
    seq_cnt    = '0;
    plain_pass = 1'b0;
    case (phase)
      PH_IDLE: begin
        plain_pass = 1'b1;
      end
      PH_SLASH: begin
        if (letter.hit) begin
          seq[seq_cnt[1:0]] = letter.code;
          seq_cnt = seq_cnt + 3'd1;
        end else if (!is_octal) begin
          seq[seq_cnt[1:0]] = BACKSLASH;
          seq_cnt = seq_cnt + 3'd1;
          plain_pass = 1'b1;
        end
      end
      PH_ONE: begin
        if (!is_octal) begin
          seq[seq_cnt[1:0]] = BACKSLASH;
          seq_cnt = seq_cnt + 3'd1;
          seq[seq_cnt[1:0]] = digit_char(digits[2:0]);
          seq_cnt = seq_cnt + 3'd1;
          plain_pass = 1'b1;
        end
      end
      PH_TWO: begin
        if (is_octal && octal_value != 9'd0 && !octal_value[8]) begin
          seq[seq_cnt[1:0]] = octal_value[7:0];
          seq_cnt = seq_cnt + 3'd1;
        end else begin
          // zero or oversized value, or a broken sequence: pass literally
          seq[seq_cnt[1:0]] = BACKSLASH;
          seq_cnt = seq_cnt + 3'd1;
          seq[seq_cnt[1:0]] = digit_char(digits[5:3]);
          seq_cnt = seq_cnt + 3'd1;
          seq[seq_cnt[1:0]] = digit_char(digits[2:0]);
          seq_cnt = seq_cnt + 3'd1;
          if (is_octal) begin
            seq[seq_cnt[1:0]] = hold_byte;
            seq_cnt = seq_cnt + 3'd1;
          end else begin
            plain_pass = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    if (plain_pass && hold_byte != BACKSLASH) begin
      seq[seq_cnt[1:0]] = hold_byte;
      seq_cnt = seq_cnt + 3'd1;
    end
    if (hold_last && mid_phase != PH_IDLE) begin
      seq[seq_cnt[1:0]] = BACKSLASH;
      seq_cnt = seq_cnt + 3'd1;
      if (mid_phase == PH_TWO) begin
        seq[seq_cnt[1:0]] = digit_char(mid_digits[5:3]);
        seq_cnt = seq_cnt + 3'd1;
      end
      if (mid_phase == PH_ONE || mid_phase == PH_TWO) begin
        seq[seq_cnt[1:0]] = digit_char(mid_digits[2:0]);
        seq_cnt = seq_cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      digits   <= '0;
      res_left <= '0;
      res_idx  <= '0;
    end else if (move) begin
      phase    <= phase_next;
      digits   <= digits_next;
      res_left <= seq_cnt;
      res_idx  <= '0;
    end else if (take) begin
      res_left <= res_left - 3'd1;
      res_idx  <= res_idx + 2'd1;
    end
    if (move) begin
      res_byte <= seq;
      res_end  <= hold_last;
    end
  end

  assign out_valid     = res_left != 3'd0;
  assign plain_byte    = res_byte[res_idx];
  assign end_of_output = res_end && (res_left == 3'd1);

`ifndef SYNTHESIS
  a_left_bounded: assert property (@(posedge clk) disable iff (rst)
    res_left <= 3'(MaxResults))
    else $error("result count exceeds four");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, res_idx} + res_left) <= 3'(MaxResults))
    else $error("result index runs past the loaded list");

  a_last_idles: assert property (@(posedge clk) disable iff (rst)
    (move && hold_last) |=> (phase == PH_IDLE && digits == '0))
    else $error("escape state survives end of text");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (take && res_left == 3'd1 && !move) |=> !out_valid)
    else $error("result register not empty after final byte taken");

  a_stall_blocks_move: assert property (@(posedge clk) disable iff (rst)
    (move && seq_cnt != 3'd0) |=> out_valid)
    else $error("loaded results not presented");
`endif

endmodule
